@@ rtl/hcmg_pkg.sv @@
// hcmg_pkg: shared types, constants and decode functions of the hilbert curve move generator
// used by hcmg_ctrl, hcmg_datapath and hilbert_curve_move_generator_unit; no dependencies
package hcmg_pkg;

  // default stack depth, i.e. the deepest order the walk supports
  localparam int unsigned MAX_ORDER_DEF = 8;

  localparam int unsigned ORDER_W = 4;
  localparam int unsigned SEG_W   = 4;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HAND  = 2'd2;

  // reset values of the configuration registers
  localparam logic [ORDER_W-1:0] CURVE_ORDER_RST = 4'd7;
  localparam logic [SEG_W-1:0]   SEG_LENGTH_RST  = 4'd8;
  localparam logic               START_HAND_RST  = 1'b1;

  // heading codes and turn increments (mod 4)
  localparam logic [1:0] HEAD_DOWN  = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_UP    = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd3;

  // segment length limits and the nibble bias
  localparam logic [SEG_W-1:0] SEG_MIN   = 4'd1;
  localparam logic [SEG_W-1:0] SEG_MAX   = 4'd8;
  localparam logic [3:0]       NIB_BIAS  = 4'd8;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd10;

  // procedure body step codes
  localparam logic [STEP_W-1:0] ST_TURN_A0  = 4'd0;
  localparam logic [STEP_W-1:0] ST_CALL_X0  = 4'd1;
  localparam logic [STEP_W-1:0] ST_FWD0     = 4'd2;
  localparam logic [STEP_W-1:0] ST_TURN_B0  = 4'd3;
  localparam logic [STEP_W-1:0] ST_CALL_S0  = 4'd4;
  localparam logic [STEP_W-1:0] ST_FWD1     = 4'd5;
  localparam logic [STEP_W-1:0] ST_CALL_S1  = 4'd6;
  localparam logic [STEP_W-1:0] ST_TURN_B1  = 4'd7;
  localparam logic [STEP_W-1:0] ST_FWD2     = 4'd8;
  localparam logic [STEP_W-1:0] ST_CALL_X1  = 4'd9;
  localparam logic [STEP_W-1:0] ST_TURN_A1  = 4'd10;

  typedef enum logic [1:0] {
    KIND_TURN,
    KIND_PUSH,
    KIND_MOVE,
    KIND_RET
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_SECOND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take_item;
    logic push_start;
    logic frame_step;
    logic emit;
    logic emit_second;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic  level_zero;
    logic  can_push;
    logic  finished;
    kind_t kind;
    logic  split;
    logic  out_free;
  } status_t;

  function automatic kind_t step_kind(input logic [STEP_W-1:0] st);
    kind_t k;
    k = KIND_RET;
    unique case (st)
      ST_TURN_A0, ST_TURN_B0, ST_TURN_B1, ST_TURN_A1: k = KIND_TURN;
      ST_CALL_X0, ST_CALL_S0, ST_CALL_S1, ST_CALL_X1: k = KIND_PUSH;
      ST_FWD0, ST_FWD1, ST_FWD2:                      k = KIND_MOVE;
      default:                                        k = KIND_RET;
    endcase
    return k;
  endfunction

  // turn a is right for the right-handed body, turn b the opposite
  function automatic logic [1:0] turn_amount(input logic [STEP_W-1:0] st, input logic hand);
    logic turn_a;
    turn_a = (st == ST_TURN_A0) || (st == ST_TURN_A1);
    return (turn_a == hand) ? TURN_RIGHT : TURN_LEFT;
  endfunction

  // the outer calls use the other hand, the inner calls the same hand
  function automatic logic push_hand(input logic [STEP_W-1:0] st, input logic hand);
    return ((st == ST_CALL_X0) || (st == ST_CALL_X1)) ? ~hand : hand;
  endfunction

endpackage

@@ rtl/hcmg_ctrl.sv @@
// hcmg_ctrl: state machine sequencing one request through the frame walk
// depends on hcmg_pkg; drives the commands of hcmg_datapath
module hcmg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hcmg_pkg::status_t sts,
  output hcmg_pkg::cmd_t    cmd
);

  hcmg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcmg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hcmg_pkg::S_IDLE: begin
        if (in_valid) state_next = hcmg_pkg::S_START;
      end
      hcmg_pkg::S_START: begin
        priority if (sts.finished) state_next = hcmg_pkg::S_DONE;
        else if (sts.level_zero && !sts.can_push) state_next = hcmg_pkg::S_DONE;
        else state_next = hcmg_pkg::S_WALK;
      end
      hcmg_pkg::S_WALK: begin
        priority if (sts.level_zero) state_next = hcmg_pkg::S_DONE;
        else if (sts.kind == hcmg_pkg::KIND_MOVE && sts.out_free) begin
          state_next = sts.split ? hcmg_pkg::S_SECOND : hcmg_pkg::S_IDLE;
        end
      end
      hcmg_pkg::S_SECOND: begin
        if (sts.out_free) state_next = hcmg_pkg::S_IDLE;
      end
      hcmg_pkg::S_DONE: begin
        if (sts.out_free) state_next = hcmg_pkg::S_IDLE;
      end
      default: state_next = hcmg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      hcmg_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      hcmg_pkg::S_START: begin
        cmd.push_start = !sts.finished && sts.level_zero && sts.can_push;
      end
      hcmg_pkg::S_WALK: begin
        if (!sts.level_zero) begin
          if (sts.kind == hcmg_pkg::KIND_MOVE) cmd.emit = sts.out_free;
          else cmd.frame_step = 1'b1;
        end
      end
      hcmg_pkg::S_SECOND: cmd.emit_second = sts.out_free;
      hcmg_pkg::S_DONE:   cmd.emit_done   = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/hcmg_datapath.sv @@
// hcmg_datapath: configuration registers, turtle heading, frame stack and output register
// depends on hcmg_pkg; commanded by hcmg_ctrl
module hcmg_datapath #(
  parameter int unsigned MAX_ORDER = hcmg_pkg::MAX_ORDER_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [hcmg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcmg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            restart,
  input  hcmg_pkg::cmd_t                  cmd,
  output hcmg_pkg::status_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      code_byte,
  output logic                            last_of_move,
  output logic                            curve_done
);

  localparam int unsigned LW = $clog2(MAX_ORDER + 1);
  localparam int unsigned IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned OW = hcmg_pkg::ORDER_W;

  logic [hcmg_pkg::ORDER_W-1:0] curve_order;
  logic [hcmg_pkg::SEG_W-1:0]   seg_length;
  logic                         start_hand;

  logic [1:0]    heading;
  logic [LW-1:0] stack_level;
  logic          walk_finished;

  logic                        frame_hand [MAX_ORDER];
  logic [hcmg_pkg::STEP_W-1:0] frame_step [MAX_ORDER];

  logic [LW-1:0] level_dec;
  logic [IW-1:0] top_idx;
  logic [IW-1:0] push_idx;
  logic          top_hand;
  logic [hcmg_pkg::STEP_W-1:0] top_step;
  hcmg_pkg::kind_t kind;
  logic          can_push;
  logic          out_free;

  logic [hcmg_pkg::SEG_W-1:0] seg_eff;
  logic       split;
  logic [3:0] mag;
  logic [3:0] nib_pos;
  logic [3:0] nib_neg;
  logic [7:0] move_byte;

  assign level_dec = stack_level - LW'(1);
  assign top_idx   = level_dec[IW-1:0];
  assign push_idx  = stack_level[IW-1:0];
  assign top_hand  = frame_hand[top_idx];
  assign top_step  = frame_step[top_idx];
  assign kind      = hcmg_pkg::step_kind(top_step);

  // push needs room below both the configured order and the stack depth
  assign can_push = (OW'(stack_level) < curve_order) &&
                    (stack_level < LW'(MAX_ORDER));
  assign out_free = !out_valid || out_ready;

  // segment length clamp to 1..8
  always_comb begin
    priority if (seg_length < hcmg_pkg::SEG_MIN) seg_eff = hcmg_pkg::SEG_MIN;
    else if (seg_length > hcmg_pkg::SEG_MAX) seg_eff = hcmg_pkg::SEG_MAX;
    else seg_eff = seg_length;
  end

  // only a positive full-length delta is split, into two equal halves
  assign split   = (seg_eff == hcmg_pkg::SEG_MAX) &&
                   ((heading == hcmg_pkg::HEAD_DOWN) || (heading == hcmg_pkg::HEAD_RIGHT));
  assign mag     = split ? (seg_eff >> 1) : seg_eff;
  assign nib_pos = hcmg_pkg::NIB_BIAS + mag;
  assign nib_neg = hcmg_pkg::NIB_BIAS - seg_eff;

  always_comb begin
    unique case (heading)
      hcmg_pkg::HEAD_DOWN:  move_byte = {hcmg_pkg::NIB_BIAS, nib_pos};
      hcmg_pkg::HEAD_RIGHT: move_byte = {nib_pos, hcmg_pkg::NIB_BIAS};
      hcmg_pkg::HEAD_UP:    move_byte = {hcmg_pkg::NIB_BIAS, nib_neg};
      default:              move_byte = {nib_neg, hcmg_pkg::NIB_BIAS};
    endcase
  end

  always_comb begin
    sts            = '0;
    sts.level_zero = (stack_level == '0);
    sts.can_push   = can_push;
    sts.finished   = walk_finished;
    sts.kind       = kind;
    sts.split      = split;
    sts.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order   <= hcmg_pkg::CURVE_ORDER_RST;
      seg_length    <= hcmg_pkg::SEG_LENGTH_RST;
      start_hand    <= hcmg_pkg::START_HAND_RST;
      heading       <= hcmg_pkg::HEAD_DOWN;
      stack_level   <= '0;
      walk_finished <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          hcmg_pkg::REG_CURVE_ORDER: curve_order <= cfg_data;
          hcmg_pkg::REG_SEG_LENGTH:  seg_length  <= cfg_data;
          hcmg_pkg::REG_START_HAND:  start_hand  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.take_item && restart) begin
        heading       <= hcmg_pkg::HEAD_DOWN;
        stack_level   <= '0;
        walk_finished <= 1'b0;
      end
      if (cmd.push_start) stack_level <= LW'(1);
      if (cmd.frame_step) begin
        unique case (kind)
          hcmg_pkg::KIND_RET:  stack_level <= level_dec;
          hcmg_pkg::KIND_TURN: heading <= heading + hcmg_pkg::turn_amount(top_step, top_hand);
          hcmg_pkg::KIND_PUSH: begin
            if (can_push) stack_level <= stack_level + LW'(1);
          end
          default: ;
        endcase
      end
      // a load refills the register, otherwise a taken byte empties it
      if (cmd.emit || cmd.emit_second || cmd.emit_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit_done) walk_finished <= 1'b1;
    end
  end

  // frame stack and result payload
  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      frame_hand[0] <= start_hand;
      frame_step[0] <= '0;
    end
    if (cmd.frame_step || cmd.emit) begin
      if (kind != hcmg_pkg::KIND_RET) frame_step[top_idx] <= top_step + 4'd1;
    end
    if (cmd.frame_step && kind == hcmg_pkg::KIND_PUSH && can_push) begin
      frame_hand[push_idx] <= hcmg_pkg::push_hand(top_step, top_hand);
      frame_step[push_idx] <= '0;
    end
    if (cmd.emit) begin
      code_byte    <= move_byte;
      last_of_move <= !split;
      curve_done   <= 1'b0;
    end
    if (cmd.emit_second) begin
      code_byte    <= move_byte;
      last_of_move <= 1'b1;
      curve_done   <= 1'b0;
    end
    if (cmd.emit_done) begin
      code_byte    <= '0;
      last_of_move <= 1'b0;
      curve_done   <= 1'b1;
    end
  end

endmodule

@@ rtl/hilbert_curve_move_generator_unit.sv @@
// hilbert_curve_move_generator_unit: top level of the hilbert curve move generator
// depends on hcmg_pkg, hcmg_ctrl and hcmg_datapath
//
//   channel   handshake             payload
//   in        in_valid / in_ready   restart
//   out       out_valid / out_ready code_byte, last_of_move, curve_done
//   cfg       cfg_valid / cfg_ready cfg_index (0 order, 1 length, 2 hand), cfg_data
//
// one request at a time: accept, a start state, then one frame step per cycle until a
// forward step, whose byte waits only for room in the output register; a split move
// loads a second byte; a done result comes once the walk has finished, or when the
// walk unwinds to its end in that request
// reset is synchronous and active high; it restores the register defaults (order 7,
// length 8, right hand), heading down and an unstarted walk
// the next request is taken while the last result still sits in the output register;
// the walk only stalls when it has a byte to load and that register is still full
// configuration writes are always taken and act at once
module hilbert_curve_move_generator_unit #(
  parameter int unsigned MAX_ORDER = hcmg_pkg::MAX_ORDER_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hcmg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcmg_pkg::CFG_DATA_W-1:0] cfg_data,
  // requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            restart,
  // results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      code_byte,
  output logic                            last_of_move,
  output logic                            curve_done
);

  hcmg_pkg::cmd_t    cmd;
  hcmg_pkg::status_t sts;

  // registers are plain flops, a write never has to wait
  assign cfg_ready = 1'b1;

  // sequencer: start, frame walk, byte loads
  hcmg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // heading, frame stack, encoder and output register
  hcmg_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (restart),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_byte    (code_byte),
    .last_of_move (last_of_move),
    .curve_done   (curve_done)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking testbench of hilbert_curve_move_generator_unit
// depends on hcmg_pkg and the unit; a built-in turtle walk predicts every output byte
module tb;
  import hcmg_pkg::*;

  localparam int unsigned WALK_DEPTH = MAX_ORDER_DEF;
  // index 3 is unmapped, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int RANDOM_REQUESTS = 800;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       done;
  } move_byte_t;

  // clock, reset and dut inputs, all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic restart = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  logic [7:0] code_byte;
  logic last_of_move, curve_done;

  hilbert_curve_move_generator_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready), .code_byte(code_byte),
    .last_of_move(last_of_move), .curve_done(curve_done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // requests waiting to be offered, and bytes the walk still owes us
  logic pending_restarts[$];
  move_byte_t awaited_bytes[$];
  int requests_queued = 0;
  int requests_taken = 0;
  int reg_writes = 0;
  int mismatches = 0;
  bit req_fire = 1'b0;

  // idling percentages, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off
  bit pressure_due = 1'b0;
  bit hold_armed = 1'b1;
  int hold_left = 0;

  // predictor copy of the registers and of the walk
  logic [ORDER_W-1:0] order_reg;
  logic [SEG_W-1:0]   length_reg;
  logic               hand_reg;
  logic [1:0]         heading;
  logic               frame_hands[WALK_DEPTH];
  logic [STEP_W-1:0]  frame_steps[WALK_DEPTH];
  int unsigned        walk_level;
  bit                 walk_finished;

  task automatic flag_mismatch(input string what);
    if (mismatches < 100) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] pack_delta(input int dx, input int dy);
    logic [3:0] hx, hy;
    hx = 4'(dx + 8);
    hy = 4'(dy + 8);
    return {hx, hy};
  endfunction

  // descend one level unless the order (saturated to the stack depth) is reached
  function automatic void push_frame(input logic hand);
    int unsigned lim;
    lim = (order_reg > WALK_DEPTH) ? WALK_DEPTH : order_reg;
    if (walk_level < lim) begin
      frame_hands[walk_level] = hand;
      frame_steps[walk_level] = ST_TURN_A0;
      walk_level++;
    end
  endfunction

  // one tick of the turtle: walk frames until a forward step, or report done
  function automatic void walk_tick(input logic rs);
    int unsigned idx;
    logic h;
    logic [STEP_W-1:0] st;
    bit emitted;
    int s, dx, dy, mx, my;
    emitted = 1'b0;
    if (rs) begin
      heading = HEAD_DOWN;
      walk_level = 0;
      walk_finished = 1'b0;
    end
    if (!walk_finished && walk_level == 0) begin
      push_frame(hand_reg);
      // order zero: nothing could be pushed
      if (walk_level == 0) walk_finished = 1'b1;
    end
    if (!walk_finished) begin
      while (walk_level > 0 && !emitted) begin
        idx = walk_level - 1;
        h = frame_hands[idx];
        st = frame_steps[idx];
        if (st > LAST_STEP) begin
          walk_level--;
        end else begin
          frame_steps[idx] = st + 1'b1;
          case (st)
            ST_TURN_A0, ST_TURN_A1: heading = heading + (h ? TURN_RIGHT : TURN_LEFT);
            ST_TURN_B0, ST_TURN_B1: heading = heading + (h ? TURN_LEFT : TURN_RIGHT);
            ST_CALL_X0, ST_CALL_X1: push_frame(~h);
            ST_CALL_S0, ST_CALL_S1: push_frame(h);
            default: begin
              // length 0 acts as the minimum, anything above 8 as 8
              s = int'((length_reg < SEG_MIN) ? SEG_MIN :
                       (length_reg > SEG_MAX) ? SEG_MAX : length_reg);
              dx = 0;
              dy = 0;
              case (heading)
                HEAD_DOWN: dy = s;
                HEAD_RIGHT: dx = s;
                HEAD_UP: dy = -s;
                default: dx = -s;
              endcase
              // a positive delta of 8 does not fit a nibble, so it goes out in halves
              if (dx > 7 || dy > 7) begin
                mx = (dx > 0) ? dx / 2 : 0;
                my = (dy > 0) ? dy / 2 : 0;
                awaited_bytes.push_back('{code: pack_delta(mx, my), last: 1'b0, done: 1'b0});
                dx -= mx;
                dy -= my;
              end
              awaited_bytes.push_back('{code: pack_delta(dx, dy), last: 1'b1, done: 1'b0});
              emitted = 1'b1;
            end
          endcase
        end
      end
      if (!emitted) walk_finished = 1'b1;
    end
    if (!emitted) begin
      awaited_bytes.push_back('{code: 8'h00, last: 1'b0, done: 1'b1});
    end
  endfunction

  // monitor: everything is sampled at the rising edge, before the dut updates
  always @(posedge clk) begin
    move_byte_t want;
    if (rst) begin
      order_reg = CURVE_ORDER_RST;
      length_reg = SEG_LENGTH_RST;
      hand_reg = START_HAND_RST;
      heading = HEAD_DOWN;
      for (int i = 0; i < WALK_DEPTH; i++) begin
        frame_hands[i] = 1'b0;
        frame_steps[i] = '0;
      end
      walk_level = 0;
      walk_finished = 1'b0;
      req_fire = 1'b0;
    end else begin
      req_fire = in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURVE_ORDER: order_reg = cfg_data;
          REG_SEG_LENGTH: length_reg = cfg_data;
          REG_START_HAND: hand_reg = cfg_data[0];
          default: ;
        endcase
        reg_writes++;
      end
      if (req_fire) begin
        walk_tick(restart);
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        if (awaited_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h last %b done %b",
                                  code_byte, last_of_move, curve_done));
        end else begin
          want = awaited_bytes.pop_front();
          if (code_byte !== want.code)
            flag_mismatch($sformatf("code_byte %02h, expected %02h", code_byte, want.code));
          if (last_of_move !== want.last)
            flag_mismatch($sformatf("last_of_move %b, expected %b", last_of_move, want.last));
          if (curve_done !== want.done)
            flag_mismatch($sformatf("curve_done %b, expected %b", curve_done, want.done));
        end
      end
    end
  end

  // hold-off counter: once asked, the receiver is starved for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (pressure_due && hold_armed) begin
      hold_left <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // driver: offers requests and ready on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      restart <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // a request only moves on once it has been taken
      if (!in_valid || req_fire) begin
        if (pending_restarts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          restart <= pending_restarts.pop_front();
        end else begin
          in_valid <= 1'b0;
          restart <= 1'($urandom_range(0, 1));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic queue_request(input logic rs);
    pending_restarts.push_back(rs);
    requests_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int seen;
    seen = reg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (reg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // all requests taken and answered, then let the walk come to rest
  task automatic settle();
    do @(negedge clk); while (requests_taken != requests_queued || awaited_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int random_sent;
    int n;
    random_sent = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset defaults: order 7, length 8, right hand; walk starts without a restart
    // and the down and right moves of length 8 come out in halves
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (4) queue_request(1'b0);
    settle();

    // smallest curve, left hand: three moves then done for good
    write_reg(REG_CURVE_ORDER, 4'd1);
    write_reg(REG_SEG_LENGTH, 4'd1);
    write_reg(REG_START_HAND, 4'd0);
    write_reg(REG_UNMAPPED, 4'hF);
    queue_request(1'b1);
    repeat (4) queue_request(1'b0);
    settle();

    // order zero answers done straight away
    write_reg(REG_CURVE_ORDER, 4'd0);
    queue_request(1'b1);
    queue_request(1'b0);
    settle();

    // order above the stack depth saturates, length 0 acts as 1
    write_reg(REG_CURVE_ORDER, 4'd15);
    write_reg(REG_SEG_LENGTH, 4'd0);
    write_reg(REG_START_HAND, 4'd1);
    queue_request(1'b1);
    repeat (2) queue_request(1'b0);
    settle();

    // length 15 clamps to 8, so both split and negative unsplit moves appear
    write_reg(REG_CURVE_ORDER, 4'd2);
    write_reg(REG_SEG_LENGTH, 4'd15);
    write_reg(REG_START_HAND, 4'd0);
    queue_request(1'b1);
    repeat (4) queue_request(1'b0);
    settle();

    // random phases: mostly small orders so that walks run out, restarts now and then
    while (random_sent < RANDOM_REQUESTS) begin
      if (random_sent < RANDOM_REQUESTS / 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 87;
      end else if (random_sent < 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_CURVE_ORDER, 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                  : $urandom_range(1, 3)));
      if ($urandom_range(0, 3) != 0) write_reg(REG_SEG_LENGTH, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 3) != 0) write_reg(REG_START_HAND, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 15) == 0) write_reg(REG_UNMAPPED, 4'($urandom_range(0, 15)));
      n = $urandom_range(10, 60);
      // the starved phase needs plenty of requests behind the stall
      if (!pressure_due && random_sent >= 3 * RANDOM_REQUESTS / 4) n = 60;
      for (int i = 0; i < n; i++) begin
        if (i == 0) queue_request(1'($urandom_range(0, 1)));
        else queue_request($urandom_range(0, 31) == 0);
      end
      if (!pressure_due && random_sent >= 3 * RANDOM_REQUESTS / 4) pressure_due = 1'b1;
      random_sent += n;
      settle();
    end

    if (awaited_bytes.size() != 0)
      flag_mismatch($sformatf("%0d bytes never arrived", awaited_bytes.size()));
    if (mismatches == 0) begin
      $display("hilbert_curve_move_generator_unit verification clean");
    end else begin
      $display("hilbert_curve_move_generator_unit verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest plausible run
  initial begin
    #2_000_000;
    $display("hilbert_curve_move_generator_unit verification failed");
    $finish;
  end

endmodule
